>>> rtl/core/prr_pkg.sv
package prr_pkg;

  localparam int CHANNEL_BITS_DEF = 16;
  localparam int FIELD_W = 48;
  localparam int DRAW_W = 16;

  typedef enum logic [1:0] {
    ACT_DIFFUSE  = 2'd0,
    ACT_SPECULAR = 2'd1,
    ACT_TRANSMIT = 2'd2,
    ACT_ABSORB   = 2'd3
  } prr_action_t;

  typedef struct packed {
    logic [DRAW_W-1:0]  random_draw;
    logic               prior_caustic_flag;
    logic [2:0]         lobe_enables;
    logic [FIELD_W-1:0] transmission_rgb;
    logic [FIELD_W-1:0] specular_rgb;
    logic [FIELD_W-1:0] diffuse_rgb;
    logic [FIELD_W-1:0] photon_power;
  } prr_item_t;

  localparam int ITEM_W = $bits(prr_item_t);

endpackage

>>> rtl/core/prr_div_pipe.sv
module prr_div_pipe #(
  parameter int LANES  = 3,
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 16,
  parameter int QUO_W  = 16,
  parameter int SIDE_W = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    ce,
  input  logic                    in_valid,
  input  logic [LANES*NUM_W-1:0]  num,
  input  logic [LANES*DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0]       in_side,
  output logic                    out_valid,
  output logic [LANES*QUO_W-1:0]  quo,
  output logic [SIDE_W-1:0]       out_side
);

  // The upper part of each dividend must be below its divisor, so that the
  // quotient fits in QUO_W bits. One quotient bit is settled per stage.
  localparam int HI_W = NUM_W - QUO_W;

  logic                              vld  [0:QUO_W];
  logic [LANES-1:0][DEN_W-1:0]       rem  [0:QUO_W];
  logic [LANES-1:0][DEN_W-1:0]       dvs  [0:QUO_W];
  logic [LANES-1:0][QUO_W-1:0]       work [0:QUO_W];
  logic [SIDE_W-1:0]                 side [0:QUO_W];

  always_comb begin
    vld[0]  = in_valid;
    side[0] = in_side;
    for (int l = 0; l < LANES; l++) begin
      dvs[0][l]  = den[l*DEN_W +: DEN_W];
      rem[0][l]  = DEN_W'(num[l*NUM_W+QUO_W +: HI_W]);
      work[0][l] = num[l*NUM_W +: QUO_W];
    end
  end

  for (genvar s = 1; s <= QUO_W; s++) begin : g_stage
    logic [LANES-1:0][DEN_W-1:0] rem_next;
    logic [LANES-1:0][QUO_W-1:0] work_next;

    always_comb begin
      logic [DEN_W:0] trial;
      for (int l = 0; l < LANES; l++) begin
        trial = {rem[s-1][l], work[s-1][l][QUO_W-1]};
        if (trial >= {1'b0, dvs[s-1][l]}) begin
          rem_next[l]  = DEN_W'(trial - {1'b0, dvs[s-1][l]});
          work_next[l] = {work[s-1][l][QUO_W-2:0], 1'b1};
        end else begin
          rem_next[l]  = trial[DEN_W-1:0];
          work_next[l] = {work[s-1][l][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (ce) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem[s]  <= rem_next;
        work[s] <= work_next;
        dvs[s]  <= dvs[s-1];
        side[s] <= side[s-1];
      end
    end
  end

  always_comb begin
    out_valid = vld[QUO_W];
    out_side  = side[QUO_W];
    for (int l = 0; l < LANES; l++) begin
      quo[l*QUO_W +: QUO_W] = work[QUO_W][l];
    end
  end

endmodule

>>> rtl/core/prr_prob_front.sv
module prr_prob_front #(
  parameter int CHANNEL_BITS = prr_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                ce,
  input  logic                                in_valid,
  input  prr_pkg::prr_item_t                  in_item,
  output logic                                out_valid,
  output prr_pkg::prr_item_t                  out_item,
  output logic [CHANNEL_BITS-1:0]             pmax,
  output logic [2:0][2*CHANNEL_BITS-1:0]      lobe_max
);

  localparam int C     = CHANNEL_BITS;
  localparam int P_W   = 2 * C;
  localparam int EXT_W = (3 * C > prr_pkg::FIELD_W) ? 3 * C : prr_pkg::FIELD_W;

  function automatic logic [2:0][C-1:0] split_rgb(input logic [prr_pkg::FIELD_W-1:0] raw);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(raw);
    return ext[3*C-1:0];
  endfunction

  function automatic logic [P_W-1:0] max3(input logic [2:0][P_W-1:0] v);
    logic [P_W-1:0] m;
    m = (v[0] > v[1]) ? v[0] : v[1];
    return (m > v[2]) ? m : v[2];
  endfunction

  logic [2:0][C-1:0]            pw_in;
  logic [2:0][2:0][C-1:0]       rf_in;
  logic [2:0][2:0][P_W-1:0]     prod_next;
  logic                         a_vld;
  prr_pkg::prr_item_t           a_item;
  logic [2:0][2:0][P_W-1:0]     prod;
  logic [2:0][C-1:0]            pw_a;

  always_comb begin
    pw_in    = split_rgb(in_item.photon_power);
    rf_in[0] = split_rgb(in_item.diffuse_rgb);
    rf_in[1] = split_rgb(in_item.specular_rgb);
    rf_in[2] = split_rgb(in_item.transmission_rgb);
    for (int l = 0; l < 3; l++) begin
      for (int c = 0; c < 3; c++) begin
        prod_next[l][c] = P_W'(pw_in[c]) * P_W'(rf_in[l][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      a_vld     <= in_valid;
      out_valid <= a_vld;
    end
  end

  assign pw_a = split_rgb(a_item.photon_power);

  always_ff @(posedge clk) begin
    if (ce) begin
      a_item   <= in_item;
      prod     <= prod_next;
      out_item <= a_item;
      pmax     <= C'(max3({P_W'(pw_a[2]), P_W'(pw_a[1]), P_W'(pw_a[0])}));
      for (int l = 0; l < 3; l++) begin
        lobe_max[l] <= max3(prod[l]);
      end
    end
  end

endmodule

>>> rtl/core/photon_russian_roulette_unit.sv
// Photon Russian roulette unit.
// One photon hit enters on the s_ side and one decision leaves on the m_ side
// for every hit. Both sides use a valid/ready handshake; an item moves at a
// rising edge where tvalid and tready are both high.
// The block is a fixed pipeline of 3*CHANNEL_BITS+6 stages from input
// acceptance to output valid. Three bit-serial pipelined dividers set that
// depth: lobe probability, normalization and power rescaling each settle one
// quotient bit per stage.
// A new item may enter in every cycle, so the sustained rate is one item per
// cycle while the receiver takes results.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline holds and s_tready falls; nothing is lost or repeated, and the
// pipeline moves again as soon as the waiting result is taken.
// Synchronous reset clears all valid bits; the data registers are not reset.
module photon_russian_roulette_unit #(
  parameter int CHANNEL_BITS = prr_pkg::CHANNEL_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // photon_power, diffuse_rgb, specular_rgb, transmission_rgb, lobe_enables,
  // prior_caustic_flag, random_draw, zero fill
  input  logic [215:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // action, new_power, caustic_flag, saturated, zero fill
  output logic [55:0]  m_tdata
);

  localparam int C     = CHANNEL_BITS;
  localparam int P_W   = 2 * C;
  localparam int S_W   = C + 2;
  localparam int CMP_W = C + 18;
  localparam int FW    = prr_pkg::FIELD_W;
  localparam int IW    = prr_pkg::ITEM_W;
  localparam int EXT_W = (3 * C > FW) ? 3 * C : FW;
  localparam int SIDE3 = 3 + 2 + 1 + FW;
  localparam logic [S_W-1:0] ONE = S_W'(1) << C;

  function automatic logic [2:0][C-1:0] split_rgb(input logic [FW-1:0] raw);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(raw);
    return ext[3*C-1:0];
  endfunction

  logic                     ce;
  prr_pkg::prr_item_t       s_item;

  assign ce       = ~m_tvalid | m_tready;
  assign s_tready = ce;

  always_comb begin
    s_item.photon_power       = s_tdata[47:0];
    s_item.diffuse_rgb        = s_tdata[95:48];
    s_item.specular_rgb       = s_tdata[143:96];
    s_item.transmission_rgb   = s_tdata[191:144];
    s_item.lobe_enables       = s_tdata[194:192];
    s_item.prior_caustic_flag = s_tdata[195];
    s_item.random_draw        = s_tdata[211:196];
  end

  // Front: channel products and maxima.
  logic                     b_vld;
  prr_pkg::prr_item_t       b_item;
  logic [C-1:0]             b_pmax;
  logic [2:0][P_W-1:0]      b_lmax;

  prr_prob_front #(.CHANNEL_BITS(C)) u_front (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (s_tvalid),
    .in_item  (s_item),
    .out_valid(b_vld),
    .out_item (b_item),
    .pmax     (b_pmax),
    .lobe_max (b_lmax)
  );

  // Lobe probabilities.
  logic                     q1_vld;
  logic [3*C-1:0]           q1;
  logic [IW-1:0]            q1_side;

  prr_div_pipe #(
    .LANES(3), .NUM_W(P_W), .DEN_W(C), .QUO_W(C), .SIDE_W(IW)
  ) u_div_prob (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (b_vld),
    .num      (b_lmax),
    .den      ({b_pmax, b_pmax, b_pmax}),
    .in_side  (b_item),
    .out_valid(q1_vld),
    .quo      (q1),
    .out_side (q1_side)
  );

  prr_pkg::prr_item_t       q1_item;
  logic [2:0][C-1:0]        d_prob_next;
  logic                     d_vld;
  prr_pkg::prr_item_t       d_item;
  logic [2:0][C-1:0]        d_prob;
  logic [S_W-1:0]           d_total;

  always_comb begin
    q1_item = prr_pkg::prr_item_t'(q1_side);
    for (int l = 0; l < 3; l++) begin
      d_prob_next[l] = q1_item.lobe_enables[l] ? q1[l*C +: C] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (ce) begin
      d_vld <= q1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      d_item  <= q1_item;
      d_prob  <= d_prob_next;
      d_total <= S_W'(d_prob_next[0]) + S_W'(d_prob_next[1]) + S_W'(d_prob_next[2]);
    end
  end

  // Normalization.
  logic                     q2_vld;
  logic [3*C-1:0]           q2;
  logic [3*C+IW-1:0]        q2_side;

  prr_div_pipe #(
    .LANES(3), .NUM_W(P_W), .DEN_W(S_W), .QUO_W(C), .SIDE_W(3*C+IW)
  ) u_div_norm (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (d_vld),
    .num      ({d_prob[2], {C{1'b0}}, d_prob[1], {C{1'b0}}, d_prob[0], {C{1'b0}}}),
    .den      ({d_total, d_total, d_total}),
    .in_side  ({d_prob, d_item}),
    .out_valid(q2_vld),
    .quo      (q2),
    .out_side (q2_side)
  );

  // Lobe selection.
  prr_pkg::prr_item_t       q2_item;
  logic [2:0][C-1:0]        q2_prob;
  logic [2:0][C-1:0]        pn;
  logic [S_W-1:0]           q2_total;
  logic [S_W-1:0]           cum0;
  logic [S_W-1:0]           cum1;
  logic [S_W-1:0]           cum2;
  logic [CMP_W-1:0]         k_draw;
  prr_pkg::prr_action_t     e_action_next;
  logic [FW-1:0]            e_refl_next;
  logic [C-1:0]             e_prob_next;

  always_comb begin
    q2_item  = prr_pkg::prr_item_t'(q2_side[IW-1:0]);
    q2_prob  = q2_side[3*C+IW-1:IW];
    q2_total = S_W'(q2_prob[0]) + S_W'(q2_prob[1]) + S_W'(q2_prob[2]);
    for (int l = 0; l < 3; l++) begin
      pn[l] = (q2_total > ONE) ? q2[l*C +: C] : q2_prob[l];
    end
    cum0   = S_W'(pn[0]);
    cum1   = cum0 + S_W'(pn[1]);
    cum2   = cum1 + S_W'(pn[2]);
    k_draw = CMP_W'({q2_item.random_draw, {C{1'b0}}});
    e_action_next = prr_pkg::ACT_ABSORB;
    e_refl_next   = q2_item.transmission_rgb;
    e_prob_next   = pn[2];
    if (split_rgb(q2_item.photon_power) != '0) begin
      if (k_draw < {cum0, 16'b0}) begin
        e_action_next = prr_pkg::ACT_DIFFUSE;
        e_refl_next   = q2_item.diffuse_rgb;
        e_prob_next   = pn[0];
      end else if (k_draw < {cum1, 16'b0}) begin
        e_action_next = prr_pkg::ACT_SPECULAR;
        e_refl_next   = q2_item.specular_rgb;
        e_prob_next   = pn[1];
      end else if (k_draw < {cum2, 16'b0}) begin
        e_action_next = prr_pkg::ACT_TRANSMIT;
      end
    end
  end

  logic                     e_vld;
  prr_pkg::prr_action_t     e_action;
  logic [FW-1:0]            e_power;
  logic                     e_prior;
  logic [FW-1:0]            e_refl;
  logic [C-1:0]             e_prob;
  logic [2:0][C-1:0]        e_pw;
  logic [2:0][C-1:0]        e_rf;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (ce) begin
      e_vld <= q2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      e_action <= e_action_next;
      e_power  <= q2_item.photon_power;
      e_prior  <= q2_item.prior_caustic_flag;
      e_refl   <= e_refl_next;
      e_prob   <= e_prob_next;
    end
  end

  assign e_pw = split_rgb(e_power);
  assign e_rf = split_rgb(e_refl);

  // Rescale products.
  logic                     f_vld;
  prr_pkg::prr_action_t     f_action;
  logic [FW-1:0]            f_power;
  logic                     f_prior;
  logic [C-1:0]             f_prob;
  logic [2:0][P_W-1:0]      f_prod;
  logic [2:0]               f_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (ce) begin
      f_vld <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      f_action <= e_action;
      f_power  <= e_power;
      f_prior  <= e_prior;
      f_prob   <= e_prob;
      for (int c = 0; c < 3; c++) begin
        f_prod[c] <= P_W'(e_pw[c]) * P_W'(e_rf[c]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      f_sat[c] = f_prod[c][P_W-1:C] >= f_prob;
    end
  end

  logic                     q3_vld;
  logic [3*C-1:0]           q3;
  logic [SIDE3-1:0]         q3_side;

  prr_div_pipe #(
    .LANES(3), .NUM_W(P_W), .DEN_W(C), .QUO_W(C), .SIDE_W(SIDE3)
  ) u_div_scale (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (f_vld),
    .num      (f_prod),
    .den      ({f_prob, f_prob, f_prob}),
    .in_side  ({f_sat, f_action, f_prior, f_power}),
    .out_valid(q3_vld),
    .quo      (q3),
    .out_side (q3_side)
  );

  // Output register.
  logic [2:0]               g_sat;
  prr_pkg::prr_action_t     g_action;
  logic                     g_prior;
  logic [FW-1:0]            g_power;
  logic [2:0][C-1:0]        g_chan;
  logic [FW-1:0]            g_new_power;
  logic                     g_caustic;
  logic                     g_saturated;
  prr_pkg::prr_action_t     m_action;
  logic [FW-1:0]            m_new_power;
  logic                     m_caustic;
  logic                     m_saturated;

  always_comb begin
    g_power  = q3_side[FW-1:0];
    g_prior  = q3_side[FW];
    g_action = prr_pkg::prr_action_t'(q3_side[FW+2:FW+1]);
    g_sat    = q3_side[FW+5:FW+3];
    for (int c = 0; c < 3; c++) begin
      g_chan[c] = g_sat[c] ? {C{1'b1}} : q3[c*C +: C];
    end
    if (g_action == prr_pkg::ACT_ABSORB) begin
      g_new_power = g_power;
      g_caustic   = g_prior;
      g_saturated = 1'b0;
    end else begin
      g_new_power = FW'(g_chan);
      g_caustic   = g_prior | (g_action != prr_pkg::ACT_DIFFUSE);
      g_saturated = |g_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= q3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_action    <= g_action;
      m_new_power <= g_new_power;
      m_caustic   <= g_caustic;
      m_saturated <= g_saturated;
    end
  end

  assign m_tdata = {4'b0000, m_saturated, m_caustic, m_new_power, m_action};

endmodule

>>> tb/tb.sv
module tb;

  localparam int CB = 16;
  localparam logic [16:0] ONE = 17'h10000;

  typedef struct {
    prr_pkg::prr_action_t action;
    logic [47:0]          new_power;
    logic                 caustic;
    logic                 saturated;
  } decision_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [215:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [55:0]  m_tdata;

  photon_russian_roulette_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  logic [215:0] hit_queue[$];
  decision_t    decision_queue[$];
  int           errors = 0;
  bit           calm = 0;
  bit           hold_go = 0;
  bit           holding = 0;
  bit           pause_sender = 0;

  function automatic logic [15:0] ch(input logic [47:0] v, input int i);
    return 16'(v >> (16 * (2 - i)));
  endfunction

  function automatic logic [63:0] lobe_probability(input logic [47:0] pw, input logic [47:0] rf,
                                                   input logic [63:0] pmax);
    logic [63:0] m, p;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      p = 64'(ch(pw, i)) * 64'(ch(rf, i));
      if (p > m) m = p;
    end
    return m / pmax;
  endfunction

  function automatic decision_t roulette(input logic [215:0] d);
    decision_t r;
    logic [47:0] pw, rf;
    logic [63:0] pmax, pd, ps, pt, total, k, prob, v;
    logic [2:0] en;
    pw = d[47:0];
    en = d[194:192];
    r.action = prr_pkg::ACT_ABSORB;
    r.new_power = pw;
    r.caustic = d[195];
    r.saturated = 1'b0;
    pmax = 0;
    for (int i = 0; i < 3; i++) if (64'(ch(pw, i)) > pmax) pmax = 64'(ch(pw, i));
    if (pmax != 0) begin
      pd = en[0] ? lobe_probability(pw, d[95:48], pmax) : 64'd0;
      ps = en[1] ? lobe_probability(pw, d[143:96], pmax) : 64'd0;
      pt = en[2] ? lobe_probability(pw, d[191:144], pmax) : 64'd0;
      total = pd + ps + pt;
      if (total > ONE) begin
        pd = pd * ONE / total;
        ps = ps * ONE / total;
        pt = pt * ONE / total;
      end
      k = 64'(d[211:196]) << CB;
      if (k < (pd << 16)) begin
        r.action = prr_pkg::ACT_DIFFUSE; rf = d[95:48]; prob = pd;
      end else if (k < ((pd + ps) << 16)) begin
        r.action = prr_pkg::ACT_SPECULAR; rf = d[143:96]; prob = ps; r.caustic = 1'b1;
      end else if (k < ((pd + ps + pt) << 16)) begin
        r.action = prr_pkg::ACT_TRANSMIT; rf = d[191:144]; prob = pt; r.caustic = 1'b1;
      end
      if (r.action != prr_pkg::ACT_ABSORB) begin
        for (int i = 0; i < 3; i++) begin
          v = 64'(ch(pw, i)) * 64'(ch(rf, i)) / prob;
          if (v > 64'hFFFF) begin
            v = 64'hFFFF;
            r.saturated = 1'b1;
          end
          r.new_power[16*(2-i) +: 16] = v[15:0];
        end
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] rand_channel();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] rand_rgb();
    return {rand_channel(), rand_channel(), rand_channel()};
  endfunction

  function automatic logic [215:0] make_hit(input logic [47:0] pw, input logic [47:0] df,
                                            input logic [47:0] sp, input logic [47:0] tr,
                                            input logic [2:0] en, input logic pc,
                                            input logic [15:0] k);
    return {4'b0, k, pc, en, tr, sp, df, pw};
  endfunction

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  initial begin
    wait (hold_go);
    holding = 1;
    repeat (300) @(posedge clk);
    holding = 0;
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (holding) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 7);
      end
      if (!s_tvalid || s_tready) begin
        if (hit_queue.size() > 0 && !pause_sender && (calm || $urandom_range(0, 99) >= 7)) begin
          s_tdata <= hit_queue.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    decision_t exp_d;
    if (!rst) begin
      if (s_tvalid && s_tready) decision_queue.push_back(roulette(s_tdata));
      if (m_tvalid && m_tready) begin
        if (decision_queue.size() == 0) begin
          report("result with nothing expected");
        end else begin
          exp_d = decision_queue.pop_front();
          if (m_tdata[1:0] != exp_d.action)
            report($sformatf("action %0d want %0d", m_tdata[1:0], exp_d.action));
          if (m_tdata[49:2] != exp_d.new_power)
            report($sformatf("new_power %h want %h", m_tdata[49:2], exp_d.new_power));
          if (m_tdata[50] != exp_d.caustic)
            report($sformatf("caustic_flag %b want %b", m_tdata[50], exp_d.caustic));
          if (m_tdata[51] != exp_d.saturated)
            report($sformatf("saturated %b want %b", m_tdata[51], exp_d.saturated));
        end
      end
    end
  end

  initial begin
    logic [47:0] pw;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    hit_queue.push_back(make_hit('0, '1, '1, '1, 3'b111, 1'b0, 16'h0000));
    hit_queue.push_back(make_hit('0, '1, '1, '1, 3'b111, 1'b1, 16'hFFFF));
    hit_queue.push_back(make_hit('1, '1, '1, '1, 3'b111, 1'b0, 16'h0000));
    hit_queue.push_back(make_hit('1, '1, '1, '1, 3'b111, 1'b0, 16'h6000));
    hit_queue.push_back(make_hit('1, '1, '1, '1, 3'b111, 1'b0, 16'hB000));
    hit_queue.push_back(make_hit('1, '1, '1, '1, 3'b111, 1'b1, 16'hFFFF));
    hit_queue.push_back(make_hit('1, '1, '1, '1, 3'b000, 1'b0, 16'h0000));
    hit_queue.push_back(make_hit(48'h1000_1000_1000, 48'h8000_8000_8000, '0, '0, 3'b001,
                                 1'b0, 16'h7FFF));
    hit_queue.push_back(make_hit(48'h1000_1000_1000, 48'h8000_8000_8000, '0, '0, 3'b001,
                                 1'b0, 16'h8000));
    hit_queue.push_back(make_hit(48'hFFFF_0001_0000, 48'h0001_FFFF_FFFF, '0, '0, 3'b001,
                                 1'b0, 16'h0000));
    hit_queue.push_back(make_hit(48'h0000_0000_0001, '0, 48'h0000_0000_FFFF, '0, 3'b010,
                                 1'b0, 16'h0000));
    hit_queue.push_back(make_hit(48'h0001_0000_0000, '0, '0, 48'hFFFF_0000_0000, 3'b100,
                                 1'b0, 16'h0000));
    hit_queue.push_back(make_hit(48'h4000_2000_1000, 48'h4000_4000_4000, 48'h4000_4000_4000,
                                 48'h8000_8000_8000, 3'b111, 1'b0, 16'hC000));
    hit_queue.push_back(make_hit(48'h4000_2000_1000, 48'h4000_4000_4000, 48'h4000_4000_4000,
                                 48'h4000_4000_4000, 3'b111, 1'b1, 16'hC000));
    hit_queue.push_back(make_hit(48'hFFFF_FFFF_FFFF, 48'h0001_0001_0001, '0, '0, 3'b001,
                                 1'b0, 16'h0000));
    hit_queue.push_back(make_hit(48'h0000_0000_0000, 48'h1234_5678_9ABC, '1, '0, 3'b011,
                                 1'b0, 16'h1234));
    for (int i = 0; i < 1000; i++) begin
      pw = ($urandom_range(0, 15) == 0) ? 48'h0 : rand_rgb();
      hit_queue.push_back(make_hit(pw, rand_rgb(), rand_rgb(), rand_rgb(),
                                   3'($urandom), 1'($urandom), 16'($urandom)));
      if (i == 200) begin
        wait (hit_queue.size() == 0);
        hold_go = 1;
      end
      if (i == 500) begin
        wait (hit_queue.size() == 0);
        pause_sender = 1;
        wait (decision_queue.size() == 0 && !s_tvalid);
        pause_sender = 0;
        calm = 1;
      end
      if (i == 750) begin
        wait (hit_queue.size() == 0);
        calm = 0;
      end
    end
    wait (hit_queue.size() == 0 && !s_tvalid);
    wait (decision_queue.size() == 0);
    repeat (120) @(posedge clk);
    if (errors == 0 && decision_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
